### src/jsps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the joystick servo pulse slew block.
package jsps_pkg;

  localparam int SERVO_COUNT = 4;

  localparam int SEL_W      = 2;
  localparam int VALUE_W    = 12;
  localparam int PULSE_W    = 12;
  localparam int DZ_W       = 11;
  localparam int HYST_W     = 11;
  localparam int STEP_W     = 6;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int CENTRE_VALUE  = 2048;
  localparam int NEUTRAL_PULSE = 1500;
  localparam int MIN_PULSE     = 500;
  localparam int PULSE_SPAN    = 2000;
  localparam int FULL_SCALE    = 4095;

  // Product of a reading and the pulse span, and its split at 4096.
  localparam int PROD_W  = 23;
  localparam int QUOT_W  = PROD_W - VALUE_W;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [DZ_W-1:0]   DEAD_ZONE_RESET  = DZ_W'(180);
  localparam logic [HYST_W-1:0] HYSTERESIS_RESET = HYST_W'(15);
  localparam logic [STEP_W-1:0] SLEW_STEP_RESET  = STEP_W'(5);
  localparam logic [MASK_W-1:0] FAST_MASK_RESET  = MASK_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE  = 2'd0,
    REG_HYSTERESIS = 2'd1,
    REG_SLEW_STEP  = 2'd2,
    REG_FAST_MASK  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [DZ_W-1:0]   dead_zone;
    logic [HYST_W-1:0] hysteresis;
    logic [STEP_W-1:0] slew_step;
    logic [MASK_W-1:0] fast_mask;
  } cfg_t;

  // Classified request handed from the front end to the servo update stage.
  typedef struct packed {
    logic [SEL_W-1:0]   servo;
    logic [PULSE_W-1:0] target;
    logic               fast;
  } mid_item_t;

  typedef struct packed {
    logic [SEL_W-1:0]   servo;
    logic [PULSE_W-1:0] pulse;
  } out_item_t;

endpackage

### src/jsps_fifo.sv
`timescale 1ns / 1ps
// Small register-based first-in first-out queue.
module jsps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

### src/jsps_front.sv
`timescale 1ns / 1ps
// Front end: takes joystick requests, drops unknown servos and computes the target pulse.
module jsps_front #(
  parameter int SERVO_COUNT = jsps_pkg::SERVO_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [jsps_pkg::SEL_W-1:0]       servo_select,
  input  logic [jsps_pkg::VALUE_W-1:0]     stick_value,
  input  jsps_pkg::cfg_t                   cfg,
  output logic                             mid_push,
  output jsps_pkg::mid_item_t              mid_item,
  input  logic                             mid_full
);

  localparam int VW = jsps_pkg::VALUE_W;
  localparam int PW = jsps_pkg::PULSE_W;
  localparam int QW = jsps_pkg::QUOT_W;

  logic                          a_valid;
  logic [jsps_pkg::SEL_W-1:0]    a_servo;
  logic [jsps_pkg::PROD_W-1:0]   a_prod;
  logic                          a_zone;
  logic                          a_fast;
  logic                          a_load;

  logic [VW-1:0] lo_bound;
  logic [VW-1:0] hi_bound;
  logic          in_zone;
  logic          servo_ok;

  logic [QW-1:0] quot_hi;
  logic [VW:0]   rem_sum;
  logic [QW-1:0] quot;
  logic [PW-1:0] target;

  assign lo_bound = VW'(jsps_pkg::CENTRE_VALUE) - VW'(cfg.dead_zone);
  assign hi_bound = VW'(jsps_pkg::CENTRE_VALUE) + VW'(cfg.dead_zone);
  assign in_zone  = (stick_value > lo_bound) && (stick_value < hi_bound);
  assign servo_ok = (32'(servo_select) < SERVO_COUNT);

  assign mid_push = a_valid && !mid_full;
  assign a_load   = !a_valid || mid_push;
  assign full     = !a_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= push && servo_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_servo <= servo_select;
      a_prod  <= jsps_pkg::PROD_W'(stick_value * 11'(jsps_pkg::PULSE_SPAN));
      a_zone  <= in_zone;
      a_fast  <= cfg.fast_mask[servo_select];
    end
  end

  // Division by 4095: with x = a*4096 + b, x/4095 = a + (a + b >= 4095).
  // The sum stays below twice 4095, so one compare settles the quotient.
  assign quot_hi = a_prod[jsps_pkg::PROD_W-1:VW];
  assign rem_sum = (VW+1)'(quot_hi) + (VW+1)'(a_prod[VW-1:0]);
  assign quot    = quot_hi + QW'(rem_sum >= (VW+1)'(jsps_pkg::FULL_SCALE));
  assign target  = a_zone ? PW'(jsps_pkg::NEUTRAL_PULSE)
                          : PW'(jsps_pkg::MIN_PULSE) + PW'(quot);

  always_comb begin
    mid_item.servo  = a_servo;
    mid_item.target = target;
    mid_item.fast   = a_fast;
  end

endmodule

### src/jsps_back.sv
`timescale 1ns / 1ps
// Back end: per-servo slew limiting, hysteresis and pulse state.
module jsps_back #(
  parameter int SERVO_COUNT = jsps_pkg::SERVO_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  jsps_pkg::mid_item_t           mid_item,
  input  logic                          mid_empty,
  output logic                          mid_pop,
  input  jsps_pkg::cfg_t                cfg,
  output logic                          res_push,
  output jsps_pkg::out_item_t           res_item,
  input  logic                          res_full
);

  localparam int PW    = jsps_pkg::PULSE_W;
  localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  logic [PW-1:0] present [SERVO_COUNT];
  logic [PW-1:0] written [SERVO_COUNT];

  logic [IDX_W-1:0] idx;
  logic [PW-1:0]    cur;
  logic [PW-1:0]    wr;
  logic [PW-1:0]    tgt;
  logic [PW:0]      up;
  logic [PW-1:0]    dn;
  logic [PW-1:0]    slow_next;
  logic [PW-1:0]    nxt;
  logic [PW-1:0]    pulse_gap;
  logic             emit;

  assign idx = IDX_W'(mid_item.servo);
  assign cur = present[idx];
  assign wr  = written[idx];
  assign tgt = mid_item.target;

  assign mid_pop = !mid_empty && !res_full;

  assign up = (PW+1)'(cur) + (PW+1)'(cfg.slew_step);
  assign dn = (cur > PW'(cfg.slew_step)) ? cur - PW'(cfg.slew_step) : '0;

  // A slow servo moves toward the target by one step and never passes it.
  always_comb begin
    if (cur < tgt) begin
      slow_next = (up > (PW+1)'(tgt)) ? tgt : up[PW-1:0];
    end else if (cur > tgt) begin
      slow_next = (dn < tgt) ? tgt : dn;
    end else begin
      slow_next = cur;
    end
  end

  assign nxt       = mid_item.fast ? tgt : slow_next;
  assign pulse_gap = (nxt > wr) ? nxt - wr : wr - nxt;
  assign emit      = (pulse_gap > PW'(cfg.hysteresis));

  assign res_push       = mid_pop && emit;
  assign res_item.servo = mid_item.servo;
  assign res_item.pulse = nxt;

  // A fast servo only follows its target when the change is written out.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        present[i] <= PW'(jsps_pkg::NEUTRAL_PULSE);
        written[i] <= PW'(jsps_pkg::NEUTRAL_PULSE);
      end
    end else if (mid_pop) begin
      if (!mid_item.fast || emit) begin
        present[idx] <= nxt;
      end
      if (emit) begin
        written[idx] <= nxt;
      end
    end
  end

endmodule

### src/joystick_servo_pulse_slew_core.sv
`timescale 1ns / 1ps
// Top level of the joystick servo pulse slew block.
//
// Takes one joystick request per clock cycle while full is low and gives at
// most one pulse update per request. A request is mapped to a target pulse
// (1500 us inside the dead zone, otherwise 500 + value*2000/4095) in a
// two-step front end, passes through a four-entry queue, and the servo update
// stage then applies slew limiting and hysteresis to the per-servo pulse
// registers in one combinational read-modify-write, so the sustained rate is
// one request per cycle unless the output queue fills. A result passes the
// front-end register, the middle queue and the output queue on its way out.
// Configuration writes take effect at once and belong in idle time.
module joystick_servo_pulse_slew_core #(
  parameter int SERVO_COUNT = jsps_pkg::SERVO_COUNT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [jsps_pkg::SEL_W-1:0]        servo_select,
  input  logic [jsps_pkg::VALUE_W-1:0]      stick_value,
  output logic                              empty,
  input  logic                              pop,
  output logic [jsps_pkg::SEL_W-1:0]        servo_written,
  output logic [jsps_pkg::PULSE_W-1:0]      pulse_width,
  input  logic                              cfg_we,
  input  logic [jsps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jsps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  jsps_pkg::cfg_t      cfg;
  jsps_pkg::mid_item_t mid_in;
  jsps_pkg::mid_item_t mid_out;
  jsps_pkg::out_item_t res_item;
  jsps_pkg::out_item_t out_head;

  logic mid_push;
  logic mid_pop;
  logic mid_full;
  logic mid_empty;
  logic res_push;
  logic res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone  <= jsps_pkg::DEAD_ZONE_RESET;
      cfg.hysteresis <= jsps_pkg::HYSTERESIS_RESET;
      cfg.slew_step  <= jsps_pkg::SLEW_STEP_RESET;
      cfg.fast_mask  <= jsps_pkg::FAST_MASK_RESET;
    end else if (cfg_we) begin
      case (jsps_pkg::reg_index_t'(cfg_index))
        jsps_pkg::REG_DEAD_ZONE:  cfg.dead_zone  <= cfg_data[jsps_pkg::DZ_W-1:0];
        jsps_pkg::REG_HYSTERESIS: cfg.hysteresis <= cfg_data[jsps_pkg::HYST_W-1:0];
        jsps_pkg::REG_SLEW_STEP:  cfg.slew_step  <= cfg_data[jsps_pkg::STEP_W-1:0];
        jsps_pkg::REG_FAST_MASK:  cfg.fast_mask  <= cfg_data[jsps_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  jsps_front #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .servo_select (servo_select),
    .stick_value  (stick_value),
    .cfg          (cfg),
    .mid_push     (mid_push),
    .mid_item     (mid_in),
    .mid_full     (mid_full)
  );

  jsps_fifo #(
    .WIDTH ($bits(jsps_pkg::mid_item_t)),
    .DEPTH (jsps_pkg::MID_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_in),
    .rd_en   (mid_pop),
    .rd_data (mid_out),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  jsps_back #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_item  (mid_out),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .cfg       (cfg),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  jsps_fifo #(
    .WIDTH ($bits(jsps_pkg::out_item_t)),
    .DEPTH (jsps_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_item),
    .rd_en   (pop && !empty),
    .rd_data (out_head),
    .full    (res_full),
    .empty   (empty)
  );

  assign servo_written = out_head.servo;
  assign pulse_width   = out_head.pulse;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the joystick servo pulse slew block.
module testbench;
  import jsps_pkg::*;

  typedef struct {
    logic [SEL_W-1:0]   servo;
    logic [VALUE_W-1:0] value;
  } stick_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [SEL_W-1:0]      servo_select = '0;
  logic [VALUE_W-1:0]    stick_value = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [SEL_W-1:0]      servo_written;
  logic [PULSE_W-1:0]    pulse_width;
  logic                  cfg_we = 1'b0;
  reg_index_t            cfg_index = REG_DEAD_ZONE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Expected behavior: configuration copy and per-servo pulse state.
  logic [DZ_W-1:0]   dead_zone_cfg  = DEAD_ZONE_RESET;
  logic [HYST_W-1:0] hysteresis_cfg = HYSTERESIS_RESET;
  logic [STEP_W-1:0] slew_step_cfg  = SLEW_STEP_RESET;
  logic [MASK_W-1:0] fast_mask_cfg  = FAST_MASK_RESET;
  int servo_present [SERVO_COUNT];
  int servo_written_pulse [SERVO_COUNT];

  stick_req_t stick_requests[$];
  out_item_t  pulse_updates_due[$];

  int  requests_queued = 0;
  int  requests_sent   = 0;
  int  updates_checked = 0;
  int  err_count       = 0;
  int  settings_used   = 1;
  int  send_idle_pct   = 15;
  int  take_idle_pct   = 15;
  int  send_gap        = 0;
  int  take_gap        = 0;
  bit  req_taken       = 1'b0;
  bit  start_hold      = 1'b0;
  bit  hold_results    = 1'b0;

  joystick_servo_pulse_slew_core dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .servo_select  (servo_select),
    .stick_value   (stick_value),
    .empty         (empty),
    .pop           (pop),
    .servo_written (servo_written),
    .pulse_width   (pulse_width),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400_000;
    $display("TEST FAILED");
    $finish;
  end

  // Works out the pulse update that one joystick request causes, if any.
  function automatic bit predict_pulse_update(input logic [SEL_W-1:0] servo,
                                              input logic [VALUE_W-1:0] value,
                                              output int pulse);
    int lo, hi, target, nxt, gap, step;
    pulse = 0;
    lo = CENTRE_VALUE - int'(dead_zone_cfg);
    hi = CENTRE_VALUE + int'(dead_zone_cfg);
    step = int'(slew_step_cfg);
    if (int'(value) > lo && int'(value) < hi) begin
      target = NEUTRAL_PULSE;
    end else begin
      target = MIN_PULSE + int'(value) * PULSE_SPAN / FULL_SCALE;
    end
    if (fast_mask_cfg[servo]) begin
      nxt = target;
    end else begin
      nxt = servo_present[servo];
      if (nxt < target) begin
        nxt = (nxt + step > target) ? target : nxt + step;
      end else if (nxt > target) begin
        nxt = (nxt - step < target) ? target : nxt - step;
      end
      servo_present[servo] = nxt;
    end
    gap = nxt - servo_written_pulse[servo];
    if (gap < 0) gap = -gap;
    if (gap <= int'(hysteresis_cfg)) return 1'b0;
    // A fast servo only follows its target when the new value goes out.
    servo_present[servo] = nxt;
    servo_written_pulse[servo] = nxt;
    pulse = nxt;
    return 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Sender: offers queued requests, with random bursts of idle cycles.
  always @(negedge clk) begin
    stick_req_t req;
    if (!rst && (!push || req_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (stick_requests.size() == 0) begin
        push <= 1'b0;
      end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(0, 5);
        push <= 1'b0;
      end else begin
        req = stick_requests.pop_front();
        servo_select <= req.servo;
        stick_value <= req.value;
        push <= 1'b1;
      end
    end
  end

  // Receiver: pops results, with random stalls and one long hold-off.
  always @(negedge clk) begin
    if (rst || hold_results) begin
      pop <= 1'b0;
    end else if (take_gap != 0) begin
      take_gap--;
      pop <= 1'b0;
    end else if (take_idle_pct != 0 && $urandom_range(0, 99) < take_idle_pct) begin
      take_gap = $urandom_range(0, 5);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_results = 1'b1;
    repeat (60) @(posedge clk);
    hold_results = 1'b0;
  end

  // Monitor: tracks configuration writes, predicts on each accepted request
  // and checks each popped result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t due;
    int pulse;
    req_taken = push && !full;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEAD_ZONE:  dead_zone_cfg  = cfg_data[DZ_W-1:0];
          REG_HYSTERESIS: hysteresis_cfg = cfg_data[HYST_W-1:0];
          REG_SLEW_STEP:  slew_step_cfg  = cfg_data[STEP_W-1:0];
          REG_FAST_MASK:  fast_mask_cfg  = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pulse_updates_due.size() == 0) begin
          note_failure($sformatf("unexpected pulse update: servo %0d pulse %0d",
                                 servo_written, pulse_width));
        end else begin
          due = pulse_updates_due.pop_front();
          if (servo_written !== due.servo || pulse_width !== due.pulse) begin
            note_failure($sformatf("pulse update mismatch: expected servo %0d pulse %0d, got servo %0d pulse %0d",
                                   due.servo, due.pulse, servo_written, pulse_width));
          end
          updates_checked++;
        end
      end
      if (req_taken) begin
        requests_sent++;
        if (predict_pulse_update(servo_select, stick_value, pulse)) begin
          pulse_updates_due.push_back('{servo: servo_select, pulse: PULSE_W'(pulse)});
        end
      end
    end
  end

  task automatic queue_request(input int servo, input int value);
    stick_requests.push_back('{servo: SEL_W'(servo), value: VALUE_W'(value)});
    requests_queued++;
  endtask

  task automatic write_reg(input reg_index_t idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int dz, input int hyst, input int step, input int mask,
                               input int send_pct, input int take_pct);
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_HYSTERESIS, hyst);
    write_reg(REG_SLEW_STEP, step);
    write_reg(REG_FAST_MASK, mask);
    settings_used++;
    @(posedge clk);
  endtask

  // Waits for every request to go in and every update to come out, then lets
  // requests that produce nothing leave the pipeline.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (requests_sent != requests_queued || pulse_updates_due.size() != 0);
    repeat (8) @(negedge clk);
    @(posedge clk);
  endtask

  // Mostly runs of one reading held on one servo, so slow servos slew toward
  // it, mixed with dead zone edges, extremes and single noisy samples.
  task automatic queue_stick_sweeps(input int count, input int dz);
    int sel, value, reps;
    while (count > 0) begin
      sel = $urandom_range(0, SERVO_COUNT - 1);
      reps = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0: value = $urandom_range(0, 1) ? FULL_SCALE : 0;
        1, 2: begin
          value = $urandom_range(0, 1) ? CENTRE_VALUE + dz : CENTRE_VALUE - dz;
          value = value + int'($urandom_range(0, 2)) - 1;
          if (value < 0) value = 0;
          if (value > FULL_SCALE) value = FULL_SCALE;
        end
        3: begin
          value = $urandom_range(0, FULL_SCALE);
          reps = 1;
        end
        default: value = $urandom_range(0, FULL_SCALE);
      endcase
      repeat (reps) begin
        queue_request(sel, value);
        count--;
      end
    end
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    int dz, hyst, step, mask;
    for (int s = 0; s < SERVO_COUNT; s++) begin
      servo_present[s] = NEUTRAL_PULSE;
      servo_written_pulse[s] = NEUTRAL_PULSE;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: servo 3 fast, the others slewing by 5.
    queue_request(3, 0);
    queue_request(3, FULL_SCALE);
    queue_request(3, CENTRE_VALUE);
    queue_request(3, 1868);   // lower dead zone bound, not inside
    queue_request(3, 1869);
    queue_request(3, 2227);
    queue_request(3, 2228);   // upper dead zone bound, not inside
    queue_request(3, 2240);   // fast servo change within hysteresis
    queue_request(3, 'hAAA);
    queue_request(3, 'h555);
    repeat (4) queue_request(0, FULL_SCALE);
    repeat (4) queue_request(1, 0);
    repeat (2) queue_request(2, 2047);
    queue_request(2, FULL_SCALE);
    queue_request(0, CENTRE_VALUE);
    queue_request(3, FULL_SCALE);
    wait_until_idle();

    // Every request changes the pulse; the receiver holds off meanwhile so
    // the block backs up and the sender sees full.
    apply_setting(0, 0, 63, 15, 0, 0);
    start_hold = 1'b1;
    for (int k = 0; k < 40; k++) queue_request(k % 4, ((k / 4) % 2) ? FULL_SCALE : 0);
    wait_until_idle();

    // Widest dead zone and a zero slew step: slow servos stay put.
    apply_setting(2047, 0, 0, 5, 15, 15);
    for (int k = 0; k < 20; k++) begin
      case (k % 5)
        0: queue_request(k % 4, 0);
        1: queue_request(k % 4, 1);
        2: queue_request(k % 4, FULL_SCALE);
        3: queue_request(k % 4, 2);
        default: queue_request(k % 4, $urandom_range(0, FULL_SCALE));
      endcase
    end
    wait_until_idle();

    // Hysteresis so large that nothing is ever written.
    apply_setting(300, 2000, 1, 10, 15, 15);
    queue_stick_sweeps(12, 300);
    wait_until_idle();

    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 3))
        0: dz = 0;
        1: dz = 2047;
        2: dz = $urandom_range(0, 400);
        default: dz = $urandom_range(0, 2047);
      endcase
      hyst = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 30);
      step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 63);
      mask = $urandom_range(0, 15);
      if (p == 5) begin
        apply_setting(dz, hyst, step, mask, 0, 0);
      end else begin
        apply_setting(dz, hyst, step, mask, pick_pct(), pick_pct());
      end
      queue_stick_sweeps(60, dz);
      wait_until_idle();
    end

    $display("Sent %0d joystick requests under %0d register settings; %0d pulse updates checked.",
             requests_sent, settings_used, updates_checked);
    $display("Covered dead zone edges, slew, fast mode, hysteresis extremes and a full stall.");
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
